/* design/assert_macros.svh */
// Assertion macros used by the top-level design file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset
`define ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* design/bls_pkg.sv */
// Shared types and constants for the bounded stack with search
`timescale 1ns / 1ps
`default_nettype none

package bls_pkg;

  localparam int DEPTH  = 128;
  localparam int WORD_W = 32;
  localparam int CNT_W  = 8;
  localparam int GROUP  = 16;
  localparam int NGROUP = DEPTH / GROUP;

  typedef logic signed [WORD_W-1:0] word_t;
  typedef logic [CNT_W-1:0] cnt_t;

  typedef enum logic [1:0] {
    MODE_PUSH   = 2'd0,
    MODE_POP    = 2'd1,
    MODE_PEEK   = 2'd2,
    MODE_SEARCH = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_CMP,
    S_RED
  } state_t;

  // Per-cycle command broadcast to every cell
  typedef struct packed {
    logic push;
    logic pop;
    logic cmp;
  } cell_ctrl_t;

endpackage

`default_nettype wire

/* design/bls_cell.sv */
// One stack cell: holds a word and an occupied flag, shifts with its neighbors
`timescale 1ns / 1ps
`default_nettype none

module bls_cell (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire bls_pkg::cell_ctrl_t ctrl,
  input  wire bls_pkg::word_t     up_word,
  input  wire logic               up_occ,
  input  wire bls_pkg::word_t     dn_word,
  input  wire logic               dn_occ,
  input  wire bls_pkg::word_t     key,
  output bls_pkg::word_t          word,
  output logic                    occ,
  output logic                    hit
);
  import bls_pkg::*;

  // Track occupancy: push pulls from above, pop pulls from below
  always_ff @(posedge clk) begin
    if (rst) begin
      occ <= 1'b0;
    end else if (ctrl.push) begin
      occ <= up_occ;
    end else if (ctrl.pop) begin
      occ <= dn_occ;
    end
  end

  // Move the stored word along with the occupancy
  always_ff @(posedge clk) begin
    if (ctrl.push) begin
      word <= up_word;
    end else if (ctrl.pop) begin
      word <= dn_word;
    end
  end

  // Compare the held word against the search key
  always_ff @(posedge clk) begin
    hit <= ctrl.cmp & occ & (word == key);
  end

endmodule

`default_nettype wire

/* design/bls_hit_tree.sv */
// OR tree over the per-cell match flags, registered at the group level
`timescale 1ns / 1ps
`default_nettype none

module bls_hit_tree (
  input  wire logic                     clk,
  input  wire logic [bls_pkg::DEPTH-1:0] hits,
  output logic                          any_hit
);
  import bls_pkg::*;

  logic [NGROUP-1:0] grp;

  // Reduce each group of cells into one registered flag
  always_ff @(posedge clk) begin
    for (int g = 0; g < NGROUP; g++) begin
      grp[g] <= |hits[g*GROUP +: GROUP];
    end
  end

  // Final level combines the group flags
  assign any_hit = |grp;

endmodule

`default_nettype wire

/* design/bounded_lifo_stack_with_search_top.sv */
// Top level of the bounded stack: control, result register and cell chain
// Push, pop and peek: result registered in the cycle after the transfer, one item per
//   cycle while out_ready is high. Search: result via cell compare, group OR, final OR;
//   the next item is taken once the search result is loaded.
// Reset (rst, synchronous, active high) empties the stack and sets capacity to 128;
//   no clearing pass, the block takes items in the first cycle after reset.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module bounded_lifo_stack_with_search_top (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [1:0]         mode,
  input  wire bls_pkg::word_t     value,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [1:0]              status,
  output bls_pkg::word_t          data,
  output logic                    found,
  output bls_pkg::cnt_t           count,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [7:0]         cfg_data
);
  import bls_pkg::*;

  localparam cnt_t DEPTH_C = CNT_W'(DEPTH);

  state_t            state, state_next;
  cnt_t              cnt, cnt_next;
  logic [7:0]        cap;
  cnt_t              eff_cap;
  logic              full;
  logic              accept;
  logic              load_now;
  logic              load_found;
  status_t           res_status;
  word_t             res_data;
  cell_ctrl_t        ctrl;
  word_t             words [DEPTH];
  logic [DEPTH-1:0]  occs;
  logic [DEPTH-1:0]  hits;
  logic              any_hit;

  assign cfg_ready = !rst;

  // Hold the capacity register
  always_ff @(posedge clk) begin
    if (rst) begin
      cap <= 8'd128;
    end else if (cfg_valid && cfg_ready) begin
      cap <= cfg_data;
    end
  end

  // Clamp capacity to the built depth
  assign eff_cap = ({1'b0, cap} > {1'b0, DEPTH_C}) ? DEPTH_C : CNT_W'(cap);
  assign full    = (cnt >= eff_cap);
  assign accept  = in_valid && in_ready;

  // Decode the request into the cell command and the immediate result
  always_comb begin
    ctrl       = '0;
    cnt_next   = cnt;
    res_status = ST_DONE;
    res_data   = '0;
    load_now   = 1'b0;
    if (accept) begin
      unique case (mode_t'(mode))
        MODE_PUSH: begin
          load_now = 1'b1;
          if (full) begin
            res_status = ST_FULL;
          end else begin
            ctrl.push = 1'b1;
            cnt_next  = cnt + cnt_t'(1);
          end
        end
        MODE_POP: begin
          load_now = 1'b1;
          if (cnt == '0) begin
            res_status = ST_EMPTY;
          end else begin
            ctrl.pop = 1'b1;
            cnt_next = cnt - cnt_t'(1);
            res_data = words[0];
          end
        end
        MODE_PEEK: begin
          load_now = 1'b1;
          if (cnt == '0) begin
            res_status = ST_EMPTY;
          end else begin
            res_data = words[0];
          end
        end
        MODE_SEARCH: begin
          if (cnt == '0) begin
            load_now   = 1'b1;
            res_status = ST_EMPTY;
          end else begin
            ctrl.cmp = 1'b1;
          end
        end
        default: begin
          load_now = 1'b0;
        end
      endcase
    end
  end

  // Hold the entry count
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else begin
      cnt <= cnt_next;
    end
  end

  // Advance the search sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:  if (ctrl.cmp) state_next = S_CMP;
      S_CMP:   state_next = S_RED;
      S_RED:   state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready   = !rst && (state == S_IDLE) && (!out_valid || out_ready);
    load_found = (state == S_RED);
  end

  // Hold the result until its transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_now || load_found) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_now) begin
      status <= res_status;
      data   <= res_data;
      found  <= 1'b0;
      count  <= cnt_next;
    end else if (load_found) begin
      status <= ST_DONE;
      data   <= '0;
      found  <= any_hit;
      count  <= cnt;
    end
  end

  // Chain of cells, top of stack in cell zero
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    word_t up_w, dn_w;
    logic  up_o, dn_o;
    if (i == 0) begin : g_top
      assign up_w = value;
      assign up_o = 1'b1;
    end else begin : g_mid_up
      assign up_w = words[i-1];
      assign up_o = occs[i-1];
    end
    if (i == DEPTH-1) begin : g_bot
      assign dn_w = '0;
      assign dn_o = 1'b0;
    end else begin : g_mid_dn
      assign dn_w = words[i+1];
      assign dn_o = occs[i+1];
    end
    bls_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .ctrl    (ctrl),
      .up_word (up_w),
      .up_occ  (up_o),
      .dn_word (dn_w),
      .dn_occ  (dn_o),
      .key     (value),
      .word    (words[i]),
      .occ     (occs[i]),
      .hit     (hits[i])
    );
  end

  bls_hit_tree u_tree (
    .clk     (clk),
    .hits    (hits),
    .any_hit (any_hit)
  );

  // Top cell is occupied exactly when the stack is not empty
  `ASSERT_SAME(a_top_occ, 1'b1, occs[0] == (cnt != '0), "top cell occupancy disagrees with count")
  // Count never exceeds the built depth
  `ASSERT_SAME(a_cnt_bound, 1'b1, cnt <= DEPTH_C, "count above depth")
  // A search on a non-empty stack enters the compare step
  `ASSERT_NEXT(a_search_seq, ctrl.cmp, state == S_CMP, "search did not start compare")
  // The output register is free when the search result lands
  `ASSERT_SAME(a_red_free, state == S_RED, !out_valid, "search result would overwrite output")

endmodule

`default_nettype wire
